FILE: rtl/ptrt_pkg.sv
// ptrt_pkg: shared types, constants and the wrap-aware compare for the
// passive tcp rtt tracker; no dependencies
`timescale 1ns / 1ps

package ptrt_pkg;

  // default queue depths
  localparam int QueueDepth = 4;
  localparam int OutDepth   = 4;

  localparam logic [31:0] SignBit = 32'h8000_0000;

  // one observed segment, plus the front's classification
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ack_number;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic [31:0] now_ms;
    logic        ack_flag;
    logic        reverse_dir;
    logic        ts_present;
  } item_t;

  // per-direction tracking record
  typedef struct packed {
    logic        ack_waiting;
    logic        echo_waiting;
    logic [31:0] mark_time;
    logic [31:0] awaited_value;
    logic [31:0] observed_delay;
  } dir_rec_t;

  // one result item
  typedef struct packed {
    logic        sample_valid;
    logic [31:0] rtt_sample;
  } result_t;

  // x is at or past y in 32-bit sequence space
  function automatic logic at_or_past(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] diff;
    diff = x - y;
    return (diff & SignBit) == 32'd0;
  endfunction

endpackage

FILE: rtl/ptrt_fifo.sv
// ptrt_fifo: show-ahead queue with a registered head read
// depends on nothing but its parameters
`timescale 1ns / 1ps

module ptrt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    wr_ptr_next;
  logic [PW-1:0]    rd_ptr_next;
  logic [CW-1:0]    count_next;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push & ~full;
  assign pop_ok  = pop & ~empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (push_ok) begin
      wr_ptr_next = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
    end
    if (pop_ok) begin
      rd_ptr_next = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
    end
    count_next = count + CW'(push_ok) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // storage write and head read, bypassing a write to the new head slot
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= din;
    end
    if (push_ok && (wr_ptr == rd_ptr_next)) begin
      dout <= din;
    end else begin
      dout <= mem[rd_ptr_next];
    end
  end

endmodule

FILE: rtl/ptrt_front.sv
// ptrt_front: input capture register and item classification
// depends on ptrt_pkg
`timescale 1ns / 1ps

module ptrt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [31:0]    seq,
  input  logic [31:0]    ack_number,
  input  logic [31:0]    ts_value,
  input  logic [31:0]    ts_echo,
  input  logic [31:0]    now_ms,
  input  logic           ack_flag,
  input  logic           reverse_dir,
  output logic           q_push,
  output ptrt_pkg::item_t q_item,
  input  logic           q_full
);

  logic hold_valid;
  logic take;

  // stall only when the holding register cannot drain
  assign full   = hold_valid & q_full;
  assign take   = push & ~full;
  assign q_push = hold_valid & ~q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= take | (hold_valid & q_full);
    end
  end

  // capture and classify the segment
  always_ff @(posedge clk) begin
    if (take) begin
      q_item.seq         <= seq;
      q_item.ack_number  <= ack_number;
      q_item.ts_value    <= ts_value;
      q_item.ts_echo     <= ts_echo;
      q_item.now_ms      <= now_ms;
      q_item.ack_flag    <= ack_flag;
      q_item.reverse_dir <= reverse_dir;
      q_item.ts_present  <= (ts_value != 32'd0);
    end
  end

endmodule

FILE: rtl/ptrt_back.sv
// ptrt_back: direction records, ack/echo matching and sample forming
// depends on ptrt_pkg
`timescale 1ns / 1ps

module ptrt_back #(
  parameter int OUT_DEPTH = ptrt_pkg::OutDepth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  ptrt_pkg::item_t                q_item,
  output logic                           q_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           r_push,
  output ptrt_pkg::result_t              r_item
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  ptrt_pkg::dir_rec_t rec [2];
  ptrt_pkg::dir_rec_t own;
  ptrt_pkg::dir_rec_t opp;
  ptrt_pkg::dir_rec_t own_next;
  ptrt_pkg::dir_rec_t opp_next;
  logic [31:0]        delay;
  logic               delay_updated;
  logic               sample_ok;
  logic [CW:0]        room_used;
  logic               fire;

  logic               s1_valid;
  logic               s1_sample;
  logic [31:0]        s1_own_delay;
  logic [31:0]        s1_opp_delay;

  // take an item only when the result queue has room for it and the one in flight
  assign room_used = {1'b0, out_count} + (CW + 1)'(s1_valid);
  assign fire      = ~q_empty & (room_used < (CW + 1)'(OUT_DEPTH));
  assign q_pop     = fire;

  // select own and opposite records
  always_comb begin
    own = q_item.reverse_dir ? rec[1] : rec[0];
    opp = q_item.reverse_dir ? rec[0] : rec[1];
  end

  // ack/echo matching and re-arming
  always_comb begin
    own_next      = own;
    opp_next      = opp;
    delay_updated = 1'b0;
    delay         = q_item.now_ms - own.mark_time;
    if (own.ack_waiting && q_item.ack_flag &&
        ptrt_pkg::at_or_past(q_item.ack_number, own.awaited_value)) begin
      own_next.observed_delay = delay;
      own_next.ack_waiting    = 1'b0;
      delay_updated           = 1'b1;
      if (q_item.ts_present) begin
        opp_next.ack_waiting   = 1'b0;
        opp_next.echo_waiting  = 1'b1;
        opp_next.mark_time     = q_item.now_ms;
        opp_next.awaited_value = q_item.ts_value;
      end
    end else if (own.echo_waiting &&
                 ptrt_pkg::at_or_past(q_item.ts_echo, own.awaited_value)) begin
      if (delay > own.observed_delay) begin
        own_next.observed_delay = delay;
        delay_updated           = 1'b1;
      end
      own_next.echo_waiting  = 1'b0;
      opp_next.ack_waiting   = 1'b1;
      opp_next.echo_waiting  = 1'b0;
      opp_next.mark_time     = q_item.now_ms;
      opp_next.awaited_value = q_item.seq;
    end else if (!opp.ack_waiting && !opp.echo_waiting) begin
      opp_next.ack_waiting   = 1'b1;
      opp_next.echo_waiting  = 1'b0;
      opp_next.mark_time     = q_item.now_ms;
      opp_next.awaited_value = q_item.seq;
    end
    sample_ok = delay_updated && (own_next.observed_delay != 32'd0) &&
                (opp_next.observed_delay != 32'd0);
  end

  // record write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      rec[0] <= '0;
      rec[1] <= '0;
    end else if (fire) begin
      if (q_item.reverse_dir) begin
        rec[1] <= own_next;
        rec[0] <= opp_next;
      end else begin
        rec[0] <= own_next;
        rec[1] <= opp_next;
      end
    end
  end

  // sample stage: delays held here, summed on the way to the result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_sample    <= sample_ok;
      s1_own_delay <= own_next.observed_delay;
      s1_opp_delay <= opp_next.observed_delay;
    end
  end

  assign r_push              = s1_valid;
  assign r_item.sample_valid = s1_sample;
  assign r_item.rtt_sample   = s1_sample ? (s1_own_delay + s1_opp_delay) : 32'd0;

  // a record never waits for an ack and an echo at once
  a_fwd_one_wait: assert property (@(posedge clk) disable iff (rst)
    !(rec[0].ack_waiting && rec[0].echo_waiting))
    else $error("forward record waits for ack and echo");

  a_rev_one_wait: assert property (@(posedge clk) disable iff (rst)
    !(rec[1].ack_waiting && rec[1].echo_waiting))
    else $error("reverse record waits for ack and echo");

  // a sample is only formed from two real measurements
  a_sample_nonzero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_sample) |-> (s1_own_delay != 32'd0 && s1_opp_delay != 32'd0))
    else $error("sample formed with a zero delay");

  // the result queue always has room for the item in flight
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (out_count < CW'(OUT_DEPTH)))
    else $error("result queue overflow");

  // an item is taken only from a nonempty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty item queue");

endmodule

FILE: rtl/passive_tcp_rtt_tracker_core.sv
// Items pass the front capture register, item queue, back sample register, result queue.
// Throughput: one item per cycle while the result side does not stall; the record
// update is a read-modify-write of two registered direction records.
// Full rises only when the item queue backs up behind a stalled result side.
// Reset (rst, synchronous): clears both direction records and empties all queues.
// Top level: front capture, item queue, back record logic, result queue; depends on ptrt_pkg
`timescale 1ns / 1ps

module passive_tcp_rtt_tracker_core #(
  parameter int QUEUE_DEPTH = ptrt_pkg::QueueDepth,
  parameter int OUT_DEPTH   = ptrt_pkg::OutDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] seq,
  input  logic [31:0] ack_number,
  input  logic [31:0] ts_value,
  input  logic [31:0] ts_echo,
  input  logic [31:0] now_ms,
  input  logic        ack_flag,
  input  logic        reverse_dir,
  output logic        empty,
  input  logic        pop,
  output logic        sample_valid,
  output logic [31:0] rtt_sample
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  ptrt_pkg::item_t   f_item;
  ptrt_pkg::item_t   q_item;
  ptrt_pkg::result_t r_item;
  ptrt_pkg::result_t o_item;
  logic              f_push;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [QCW-1:0]    q_count;
  logic              r_push;
  logic              r_full;
  logic [OCW-1:0]    out_count;

  // front: capture and classify
  ptrt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .seq         (seq),
    .ack_number  (ack_number),
    .ts_value    (ts_value),
    .ts_echo     (ts_echo),
    .now_ms      (now_ms),
    .ack_flag    (ack_flag),
    .reverse_dir (reverse_dir),
    .q_push      (f_push),
    .q_item      (f_item),
    .q_full      (q_full)
  );

  // item queue between front and back
  ptrt_fifo #(
    .WIDTH ($bits(ptrt_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty),
    .count (q_count)
  );

  // back: record update and sample forming
  ptrt_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_count (out_count),
    .r_push    (r_push),
    .r_item    (r_item)
  );

  // result queue
  ptrt_fifo #(
    .WIDTH ($bits(ptrt_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .din   (r_item),
    .full  (r_full),
    .pop   (pop),
    .dout  (o_item),
    .empty (empty),
    .count (out_count)
  );

  assign sample_valid = o_item.sample_valid;
  assign rtt_sample   = o_item.rtt_sample;

  // item queue occupancy stays within its depth
  a_item_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCW'(QUEUE_DEPTH))
    else $error("item queue count out of range");

  // back never pushes into a full result queue
  a_result_no_drop: assert property (@(posedge clk) disable iff (rst)
    r_push |-> !r_full)
    else $error("result dropped at full queue");

  // front never pushes into a full item queue
  a_item_no_drop: assert property (@(posedge clk) disable iff (rst)
    f_push |-> !q_full)
    else $error("item dropped at full queue");

endmodule
